// ===== src/ntrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntrs_pkg
// Shared constants and controller/datapath interface types for the nearest
// occupied tile ring search.
// ----------------------------------------------------------------------------
package ntrs_pkg;

  // Default board geometry and tile width
  localparam int BOARD_SIDE_DEF = 32;
  localparam int TEAM_BITS_DEF  = 8;

  // Fixed field widths
  localparam int COORD_W     = 5;
  localparam int OWN_TEAM_W  = 8;
  localparam int RING_W      = 7;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;
  // Signed width of a scanned cell coordinate, covers -127..158 and the board side
  localparam int POS_W       = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_TEAM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LIMIT = 1'd1;

  // Configuration reset values
  localparam logic [OWN_TEAM_W-1:0] OWN_TEAM_RST   = 8'd1;
  localparam logic [RING_W-1:0]     RING_LIMIT_RST = 7'd32;

  // Input action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Search mode codes
  localparam logic MODE_FRIEND = 1'b0;
  localparam logic MODE_FOE    = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;   // write zero at the clearing address, advance it
    logic wr_tile;  // store the input team id at the input tile
    logic load;     // capture search origin and restart the ring walk
    logic issue;    // read the current cell and advance the ring walk
    logic finish;   // latch the search result
  } ntrs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;    // clearing address is the last tile
    logic ring_empty;  // ring limit leaves no ring to scan
    logic gen_last;    // current cell is the last one of the search
    logic hit;         // cell checked this cycle matches
  } ntrs_stat_t;

endpackage

// ===== src/nearest_occupied_tile_ring_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_occupied_tile_ring_search
// Board of team ids with tile writes and a square ring search for the
// nearest friendly or foreign tile around an origin.
// ----------------------------------------------------------------------------
//
//  Channel    Ports                                          Flow
//  ---------  ---------------------------------------------  -----------------
//  command    start, busy, action_i, coord_x_i, coord_y_i,   start && !busy
//             tile_team_i, search_mode_i
//  result     done_o, found_o, found_x_o, found_y_o          done_o, 1 cycle
//  config     cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i
//
// A tile write leaves busy low. A search reads one board cell per cycle
// through the single read port of the board memory, four runs of 2i+1 cells
// per ring i, and ends once the check behind the registered read finds a
// match or the last cell has been checked. With ring limit 0 or 1 the result
// follows on the next cycle. After reset busy stays high while the board is
// cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module nearest_occupied_tile_ring_search #(
  parameter int BOARD_SIDE = ntrs_pkg::BOARD_SIDE_DEF,
  parameter int TEAM_BITS  = ntrs_pkg::TEAM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ntrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [ntrs_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [ntrs_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [ntrs_pkg::OWN_TEAM_W-1:0] tile_team_i,
  input  logic                            search_mode_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic [ntrs_pkg::COORD_W-1:0]    found_x_o,
  output logic [ntrs_pkg::COORD_W-1:0]    found_y_o
);

  ntrs_pkg::ntrs_cmd_t  cmd;
  ntrs_pkg::ntrs_stat_t stat;

  // Sequence clearing, writes and the scan
  ntrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // Board, ring walk and match check
  ntrs_datapath #(
    .BOARD_SIDE (BOARD_SIDE),
    .TEAM_BITS  (TEAM_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .tile_team_i   (tile_team_i),
    .search_mode_i (search_mode_i),
    .found_o       (found_o),
    .found_x_o     (found_x_o),
    .found_y_o     (found_y_o)
  );

  // A miss reports zero coordinates
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_x_o == '0) && (found_y_o == '0))
    else $error("miss result carries nonzero coordinates");

  // A result follows an accepted search or a running scan
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a transaction in progress");

  // A match is only flagged while the scan is running
  a_hit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.hit |-> busy)
    else $error("cell match outside of a scan");

  // A new transaction never starts mid-scan
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.issue && !cmd.clr_wr)
    else $error("search load overlaps scan or clearing");

endmodule

// ===== src/ntrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntrs_ctrl
// Controller state machine: board clearing after reset, tile writes, and
// sequencing of the ring scan until a hit or the last cell.
// ----------------------------------------------------------------------------
module ntrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               action_i,
  input  ntrs_pkg::ntrs_stat_t stat_i,
  output ntrs_pkg::ntrs_cmd_t  cmd_o,
  output logic               busy,
  output logic               done_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   done_q;
  logic   go_search;

  // Decode commands from the current state
  always_comb begin
    go_search     = (state_q == ST_IDLE) && start && (action_i == ntrs_pkg::ACT_SEARCH);
    cmd_o         = '0;
    cmd_o.clr_wr  = (state_q == ST_CLEAR);
    cmd_o.wr_tile = (state_q == ST_IDLE) && start && (action_i == ntrs_pkg::ACT_WRITE);
    cmd_o.load    = go_search;
    cmd_o.issue   = (state_q == ST_SCAN) && !stat_i.hit;
    cmd_o.finish  = (go_search && stat_i.ring_empty)
                 || ((state_q == ST_SCAN) && stat_i.hit)
                 || (state_q == ST_DRAIN);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (go_search && !stat_i.ring_empty) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.hit) state_d = ST_IDLE;
        else if (stat_i.gen_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/ntrs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntrs_datapath
// Board memory, configuration registers, ring walk address generator, one
// cell check stage behind the registered memory read, and result registers.
// ----------------------------------------------------------------------------
module ntrs_datapath #(
  parameter int BOARD_SIDE = ntrs_pkg::BOARD_SIDE_DEF,
  parameter int TEAM_BITS  = ntrs_pkg::TEAM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ntrs_pkg::ntrs_cmd_t                cmd_i,
  output ntrs_pkg::ntrs_stat_t               stat_o,
  input  logic                               cfg_we_i,
  input  logic [ntrs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ntrs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [ntrs_pkg::COORD_W-1:0]       coord_x_i,
  input  logic [ntrs_pkg::COORD_W-1:0]       coord_y_i,
  input  logic [ntrs_pkg::OWN_TEAM_W-1:0]    tile_team_i,
  input  logic                               search_mode_i,
  output logic                               found_o,
  output logic [ntrs_pkg::COORD_W-1:0]       found_x_o,
  output logic [ntrs_pkg::COORD_W-1:0]       found_y_o
);

  localparam int DEPTH = BOARD_SIDE * BOARD_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (TEAM_BITS > ntrs_pkg::OWN_TEAM_W) ? TEAM_BITS
                                                            : ntrs_pkg::OWN_TEAM_W;
  localparam int PW    = ntrs_pkg::POS_W;
  localparam int RW    = ntrs_pkg::RING_W;
  localparam int CW    = ntrs_pkg::COORD_W;

  localparam logic signed [PW-1:0] ONE  = PW'(1);
  localparam logic signed [PW-1:0] SIDE = PW'(BOARD_SIDE);

  typedef enum logic [1:0] {
    RUN_TOP,
    RUN_LEFT,
    RUN_BOTTOM,
    RUN_RIGHT
  } run_e;

  // Configuration registers
  logic [ntrs_pkg::OWN_TEAM_W-1:0] own_team_q;
  logic [RW-1:0]                   ring_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_team_q   <= ntrs_pkg::OWN_TEAM_RST;
      ring_limit_q <= ntrs_pkg::RING_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ntrs_pkg::CFG_OWN_TEAM:   own_team_q   <= cfg_data_i;
        ntrs_pkg::CFG_RING_LIMIT: ring_limit_q <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing address after reset
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Search origin and mode
  logic [CW-1:0] org_x_q, org_y_q;
  logic          mode_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      org_x_q <= coord_x_i;
      org_y_q <= coord_y_i;
      mode_q  <= search_mode_i;
    end
  end

  // Ring walk: ring radius, run within the ring, step within the run
  logic [RW-1:0] ring_q;
  logic [RW:0]   step_q;
  run_e          run_q;
  logic          run_end;

  assign run_end = (step_q == {ring_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RW'(1);
      step_q <= '0;
      run_q  <= RUN_TOP;
    end else if (cmd_i.load) begin
      ring_q <= RW'(1);
      step_q <= '0;
      run_q  <= RUN_TOP;
    end else if (cmd_i.issue) begin
      if (run_end) begin
        step_q <= '0;
        case (run_q)
          RUN_TOP:    run_q <= RUN_LEFT;
          RUN_LEFT:   run_q <= RUN_BOTTOM;
          RUN_BOTTOM: run_q <= RUN_RIGHT;
          default: begin
            run_q  <= RUN_TOP;
            ring_q <= ring_q + RW'(1);
          end
        endcase
      end else begin
        step_q <= step_q + (RW + 1)'(1);
      end
    end
  end

  // Current cell: offset along the run is step+1-radius
  logic signed [PW-1:0] ox, oy, rad, ofs, cx, cy;
  logic                 on_board;
  logic [AW-1:0]        raddr;

  always_comb begin
    ox  = $signed(PW'(org_x_q));
    oy  = $signed(PW'(org_y_q));
    rad = $signed(PW'(ring_q));
    ofs = $signed(PW'(step_q)) + ONE - rad;
    case (run_q)
      RUN_TOP:    begin cx = ox + ofs; cy = oy - rad; end
      RUN_LEFT:   begin cx = ox - rad; cy = oy + ofs; end
      RUN_BOTTOM: begin cx = ox - ofs; cy = oy + rad; end
      default:    begin cx = ox + rad; cy = oy - ofs; end
    endcase
    on_board = (cx >= $signed(PW'(0))) && (cy >= $signed(PW'(0)))
            && (cx < SIDE) && (cy < SIDE);
    raddr    = on_board ? (AW'(cy) * AW'(BOARD_SIDE) + AW'(cx)) : '0;
  end

  // Board memory with a single write port and a registered read
  logic [TEAM_BITS-1:0] board_mem [DEPTH];
  logic [TEAM_BITS-1:0] rdata_q;
  logic [TEAM_BITS-1:0] wdata;
  logic [AW-1:0]        waddr;
  logic                 we;
  logic                 wr_on_board;
  logic [CMP_W-1:0]     team_wide;

  always_comb begin
    team_wide   = CMP_W'(tile_team_i);
    wr_on_board = ({{(PW-CW){1'b0}}, coord_x_i} < PW'(BOARD_SIDE))
               && ({{(PW-CW){1'b0}}, coord_y_i} < PW'(BOARD_SIDE));
    we          = cmd_i.clr_wr || (cmd_i.wr_tile && wr_on_board);
    if (cmd_i.clr_wr) begin
      waddr = clr_q;
      wdata = '0;
    end else begin
      waddr = AW'(coord_y_i) * AW'(BOARD_SIDE) + AW'(coord_x_i);
      wdata = team_wide[TEAM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      board_mem[waddr] <= wdata;
    end
    rdata_q <= board_mem[raddr];
  end

  // Check stage aligned with the read data
  logic                 chk_vld_q;
  logic signed [PW-1:0] chk_x_q, chk_y_q;
  logic                 tile_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.issue && on_board;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_x_q <= cx;
    chk_y_q <= cy;
  end

  always_comb begin
    if (mode_q == ntrs_pkg::MODE_FOE) begin
      tile_match = (CMP_W'(rdata_q) != CMP_W'(own_team_q));
    end else begin
      tile_match = (CMP_W'(rdata_q) == CMP_W'(own_team_q));
    end
  end

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (clr_q == AW'(DEPTH - 1));
    stat_o.ring_empty = (ring_limit_q < RW'(2));
    stat_o.gen_last   = (run_q == RUN_RIGHT) && run_end
                     && (({1'b0, ring_q} + (RW + 1)'(1)) >= {1'b0, ring_limit_q});
    stat_o.hit        = chk_vld_q && (rdata_q != '0) && tile_match;
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_o   <= stat_o.hit;
      found_x_o <= stat_o.hit ? chk_x_q[CW-1:0] : '0;
      found_y_o <= stat_o.hit ? chk_y_q[CW-1:0] : '0;
    end
  end

endmodule
